// File: sv/tad_pkg.sv
// Shared types and codes for the texel to ARGB decoder.
package tad_pkg;

    localparam logic [2:0] FMT_RGBA16 = 3'd0;
    localparam logic [2:0] FMT_RGBA32 = 3'd1;
    localparam logic [2:0] FMT_CI4    = 3'd2;
    localparam logic [2:0] FMT_CI8    = 3'd3;
    localparam logic [2:0] FMT_IA16   = 3'd4;
    localparam logic [2:0] FMT_I4     = 3'd5;
    localparam logic [2:0] FMT_I8     = 3'd6;

    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;
    localparam logic [1:0] REQ_LOOKUP = 2'd3;

    localparam logic REG_TEXEL_FORMAT = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [31:0] pixel;
        logic        last;
        logic        fin;
    } t_req;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        fin;
    } t_pix;

endpackage

// File: sv/tad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tad_issue.sv
// Input item holder that issues one palette or pixel request per cycle while each request is taken.
module tad_issue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_format,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [31:0]       i_texel,
    input  logic [7:0]        i_index,
    input  logic [31:0]       i_entry,
    input  logic              i_end,
    output logic              o_req_valid,
    output tad_pkg::t_req     o_req,
    input  logic              i_take
);
    import tad_pkg::*;

    logic        r_valid;
    logic        r_phase;
    logic        r_cmd;
    logic [31:0] r_texel;
    logic [7:0]  r_index;
    logic [31:0] r_entry;
    logic        r_end;

    logic        two_px;
    logic        last;
    logic [7:0]  b;
    logic [3:0]  nib;
    logic [4:0]  r5;
    logic [4:0]  g5;
    logic [4:0]  b5;
    t_req        req;

    always_comb begin
        b      = r_texel[7:0];
        nib    = r_phase ? b[3:0] : b[7:4];
        two_px = i_format inside {FMT_CI4, FMT_I4};
        last   = r_cmd || !two_px || r_phase;
        r5     = r_texel[15:11];
        g5     = {r_texel[10:8], r_texel[7:6]};
        b5     = r_texel[5:1];

        req.kind  = REQ_PIXEL;
        req.addr  = r_index;
        req.wdata = r_entry;
        req.pixel = 32'h0;
        req.last  = last;
        req.fin   = last && r_end;

        if (r_cmd) begin
            req.kind = REQ_WRITE;
        end else begin
            case (i_format)
                FMT_RGBA16: begin
                    req.pixel = {{8{r_texel[0]}}, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
                end
                FMT_RGBA32: begin
                    req.pixel = {r_texel[7:0], r_texel[31:8]};
                end
                FMT_CI4: begin
                    req.kind = REQ_LOOKUP;
                    req.addr = {4'h0, nib};
                end
                FMT_CI8: begin
                    req.kind = REQ_LOOKUP;
                    req.addr = b;
                end
                FMT_IA16: begin
                    req.pixel = {b, r_texel[15:8], r_texel[15:8], r_texel[15:8]};
                end
                FMT_I4: begin
                    req.pixel = {8'h00, nib, nib, nib, nib, nib, nib};
                end
                FMT_I8: begin
                    req.pixel = {8'h00, b, b, b};
                end
                default: begin
                    req.kind = REQ_NONE;
                end
            endcase
        end
    end

    assign o_req       = req;
    assign o_req_valid = r_valid;
    assign o_ready     = !r_valid || (i_take && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_phase <= 1'b0;
            r_cmd   <= i_command;
            r_texel <= i_texel;
            r_index <= i_index;
            r_entry <= i_entry;
            r_end   <= i_end;
        end else if (i_take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

endmodule

// File: sv/tad_skid.sv
// Output register with skid entry for the pixel stream.
module tad_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tad_pkg::t_pix i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tad_pkg::t_pix o_data
);
    import tad_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_pix r_out;
    t_pix r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_data;
                r_out_valid <= i_valid;
            end
        end else if (i_valid && o_ready) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// File: sv/texel_to_argb_decoder.sv
// Texel to ARGB8888 decoder top level: config port, palette RAM, pixel pipeline.
//
// Input stream (s side): tuser is the command (0 texel data, 1 palette write),
// tlast marks the last texel item of an image, tdata carries texel bytes,
// palette index and palette entry. Output stream (m side): tdata is the ARGB
// pixel, tuser flags the last pixel of an input item, tlast the final pixel
// of the image. Register texel_format at address 0 picks the texel format;
// write it only while the block is idle.
// The first pixel of an item passes the issue stage, the palette read stage and
// the output register, in that order, before it is offered. Throughput: one
// item per cycle for one-pixel formats and palette writes while the pixel path
// does not stall; the issue holder sends a CI4 or I4 item as two requests, one
// per pixel, and takes the next item with the second. A palette write goes to
// the RAM in the cycle it issues, so a later lookup of the same entry sees it.
// Reset clears the format to RGBA16 and empties the pipeline; the palette
// holds no defined contents until written. A stalled receiver backs the
// pipeline up through the skid entry to the input tready.
module texel_to_argb_decoder #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // texel_bytes[31:0], palette_index[39:32], palette_entry[71:40]
    input  logic        i_s_tuser,  // command
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // pixel_argb
    output logic        o_m_tuser,  // last_of_run
    output logic        o_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tad_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [2:0]  r_format;
    logic        req_valid;
    t_req        req;
    logic        req_take;
    logic        addr_ok;
    logic        s1_free;
    logic        s1_take;
    logic        skid_ready;
    logic        ram_we;
    logic        ram_re;
    logic [31:0] ram_rdata;
    logic        r_s1_valid;
    logic        r_s1_lut;
    t_pix        r_s1;
    t_pix        s1_out;
    t_pix        m_pix;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_TEXEL_FORMAT) ? {29'h0, r_format} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGBA16;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr[2] == REG_TEXEL_FORMAT) begin
            r_format <= i_pwdata[2:0];
        end
    end

    tad_issue u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_format    (r_format),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_command   (i_s_tuser),
        .i_texel     (i_s_tdata[31:0]),
        .i_index     (i_s_tdata[39:32]),
        .i_entry     (i_s_tdata[71:40]),
        .i_end       (i_s_tlast),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_take      (req_take)
    );

    assign addr_ok  = {1'b0, req.addr} < 9'(PALETTE_DEPTH);
    assign s1_take  = r_s1_valid && skid_ready;
    assign s1_free  = !r_s1_valid || s1_take;
    assign req_take = req_valid
                      && ((req.kind == REQ_NONE) || (req.kind == REQ_WRITE) || s1_free);
    assign ram_we   = req_take && (req.kind == REQ_WRITE) && addr_ok;
    assign ram_re   = req_take && (req.kind == REQ_LOOKUP) && addr_ok;

    tad_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (req.addr[AW-1:0]),
        .i_wdata (req.wdata),
        .i_re    (ram_re),
        .i_raddr (req.addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_take && ((req.kind == REQ_PIXEL) || (req.kind == REQ_LOOKUP))) begin
            r_s1_valid <= 1'b1;
            r_s1_lut   <= ram_re;
            r_s1.pixel <= req.pixel;
            r_s1.last  <= req.last;
            r_s1.fin   <= req.fin;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        s1_out       = r_s1;
        s1_out.pixel = r_s1_lut ? ram_rdata : r_s1.pixel;
    end

    tad_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (skid_ready),
        .i_data  (s1_out),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (m_pix)
    );

    assign o_m_tdata = m_pix.pixel;
    assign o_m_tuser = m_pix.last;
    assign o_m_tlast = m_pix.fin;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_take) |=> (r_s1_valid && $stable(s1_out)))
        else $error("stalled palette stage changed its pixel");

    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("palette written and read in one cycle");

    a_second_px: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && !req.last && ((req.kind == REQ_PIXEL) || (req.kind == REQ_LOOKUP)))
        |=> req_valid)
        else $error("item dropped before its second pixel");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser)
        else $error("final pixel not marked last of run");

endmodule

// File: tb/texel_to_argb_decoder_tb.sv
// Self-checking testbench for the texel to ARGB decoder: predicts every pixel and scores it.
module texel_to_argb_decoder_tb;
    import tad_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;  // texel_bytes[31:0], palette_index[39:32], palette_entry[71:40]
    logic        i_s_tuser = 1'b0;  // command
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;  // pixel_argb
    logic        o_m_tuser;  // last_of_run
    logic        o_m_tlast;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    texel_to_argb_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    localparam logic CMD_TEXEL = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    logic [31:0] palette_shadow [256];
    logic [2:0]  format_shadow = FMT_RGBA16;
    t_pix        pending_pixels [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int requests_sent = 0;
    int palette_writes = 0;
    int pixels_checked = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] widen5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic void queue_pixel(logic [31:0] px, logic is_last, logic fin);
        t_pix p;
        p.pixel = px;
        p.last = is_last;
        p.fin = fin;
        pending_pixels.push_back(p);
    endfunction

    function automatic void decode_request(logic cmd, logic [31:0] texel, logic [7:0] pidx,
                                           logic [31:0] pent, logic iend);
        logic [7:0] b;
        logic [3:0] hn;
        logic [3:0] ln;
        b = texel[7:0];
        hn = b[7:4];
        ln = b[3:0];
        if (cmd == CMD_PALETTE) begin
            palette_shadow[pidx] = pent;
            return;
        end
        case (format_shadow)
            FMT_RGBA16: queue_pixel({{8{texel[0]}}, widen5(texel[15:11]), widen5(texel[10:6]),
                                     widen5(texel[5:1])}, 1'b1, iend);
            FMT_RGBA32: queue_pixel({texel[7:0], texel[31:8]}, 1'b1, iend);
            FMT_CI4: begin
                queue_pixel(palette_shadow[{4'h0, hn}], 1'b0, 1'b0);
                queue_pixel(palette_shadow[{4'h0, ln}], 1'b1, iend);
            end
            FMT_CI8: queue_pixel(palette_shadow[b], 1'b1, iend);
            FMT_IA16: queue_pixel({b, {3{texel[15:8]}}}, 1'b1, iend);
            FMT_I4: begin
                queue_pixel({8'h00, {3{hn, hn}}}, 1'b0, 1'b0);
                queue_pixel({8'h00, {3{ln, ln}}}, 1'b1, iend);
            end
            FMT_I8: queue_pixel({8'h00, {3{b}}}, 1'b1, iend);
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel %h (last_of_run %b final_pixel %b)",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (o_m_tdata !== want.pixel) begin
                    $error("pixel_argb expected %h got %h", want.pixel, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tuser !== want.last) begin
                    $error("last_of_run expected %b got %b", want.last, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tlast !== want.fin) begin
                    $error("final_pixel expected %b got %b", want.fin, o_m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic cmd, logic [31:0] texel, logic [7:0] pidx,
                                logic [31:0] pent, logic iend);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = cmd;
        i_s_tlast = iend;
        i_s_tdata = {pent, pidx, texel};
        do @(posedge i_clk); while (!o_s_tready);
        decode_request(cmd, texel, pidx, pent, iend);
        requests_sent++;
        if (cmd == CMD_PALETTE)
            palette_writes++;
    endtask

    task automatic send_texel(logic [31:0] texel, logic iend);
        send_request(CMD_TEXEL, texel, 8'($urandom), $urandom, iend);
    endtask

    task automatic send_palette(logic [7:0] pidx, logic [31:0] pent);
        send_request(CMD_PALETTE, $urandom, pidx, pent, 1'($urandom));
    endtask

    // hold the stream until every pending pixel is out
    task automatic drain_pixels();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_format(logic [2:0] fmt);
        drain_pixels();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_psel = 1'b1;
        i_penable = 1'b0;
        i_pwrite = 1'b1;
        i_paddr = {REG_TEXEL_FORMAT, 2'b00};
        i_pwdata = {29'd0, fmt};
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        format_shadow = fmt;
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
    endtask

    task automatic test_rgba16();
        set_format(FMT_RGBA16);
        send_texel(32'h0000_0000, 1'b0);
        send_texel(32'hffff_ffff, 1'b1);
        send_texel(32'h1234_0001, 1'b0);
        send_texel(32'hedcb_f83e, 1'b0);
        send_texel(32'h0000_07c0, 1'b1);
    endtask

    task automatic test_rgba32();
        set_format(FMT_RGBA32);
        send_texel(32'h0000_0000, 1'b1);
        send_texel(32'hffff_ffff, 1'b0);
        send_texel(32'h1122_3344, 1'b1);
    endtask

    // a palette write followed by a lookup of the same entry checks write-before-read
    task automatic test_palette_lookup();
        set_format(FMT_CI8);
        send_palette(8'h00, 32'hffff_ffff);
        send_palette(8'hff, 32'h0000_0000);
        send_palette(8'h0f, 32'h8040_2010);
        send_texel(32'hffff_ff00, 1'b0);
        send_texel(32'h0000_00ff, 1'b1);
        send_palette(8'h5a, 32'hdead_beef);
        send_texel(32'h1234_565a, 1'b0);
        set_format(FMT_CI4);
        send_texel(32'h0000_00f0, 1'b0);
        send_texel(32'hffff_ff0f, 1'b1);
    endtask

    task automatic test_intensity();
        set_format(FMT_IA16);
        send_texel(32'hffff_00ff, 1'b1);
        send_texel(32'h0000_ff00, 1'b0);
        set_format(FMT_I4);
        send_texel(32'hffff_ff0f, 1'b1);
        send_texel(32'h0000_00f0, 1'b0);
        set_format(FMT_I8);
        send_texel(32'hffff_ff00, 1'b0);
        send_texel(32'h0000_00ff, 1'b1);
    endtask

    task automatic test_random(int s_pct, int r_pct, bit fill, bit reverse);
        logic [2:0] fmt_order [7] = '{FMT_RGBA16, FMT_RGBA32, FMT_CI4, FMT_CI8,
                                      FMT_IA16, FMT_I4, FMT_I8};
        logic [2:0] fmt;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (fill) begin
            for (int i = 0; i < 256; i++)
                send_palette(8'(i), $urandom);
        end
        for (int k = 0; k < 7; k++) begin
            fmt = reverse ? fmt_order[6 - k] : fmt_order[k];
            set_format(fmt);
            for (int n = 0; n < 6; n++) begin
                if ($urandom_range(4) == 0)
                    send_palette(8'($urandom), $urandom);
                else
                    send_texel($urandom, ($urandom_range(7) == 0));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 76;
        test_rgba16();
        test_rgba32();
        test_palette_lookup();
        test_intensity();
        test_random(7, 76, 1'b1, 1'b0);
        test_random(76, 7, 1'b0, 1'b1);
        test_random(0, 0, 1'b0, 1'b0);
        drain_pixels();
        repeat (10) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d pixels never arrived", pending_pixels.size());
            fail_count++;
        end
        $display("Covered all seven texel formats under three idling mixes: %0d requests, %0d",
                 requests_sent, palette_writes);
        $display("of them palette writes, %0d pixels scored, %0d failures.",
                 pixels_checked, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: texel_to_argb_decoder.f
sv/tad_pkg.sv
sv/tad_ram.sv
sv/tad_issue.sv
sv/tad_skid.sv
sv/texel_to_argb_decoder.sv
tb/texel_to_argb_decoder_tb.sv
